### hdl/esma_pkg.sv
// ----------------------------------------------------------------------------
// esma_pkg
// Shared types, register map and helpers of the edge-shrinking moving average.
// ----------------------------------------------------------------------------
package esma_pkg;

    // frame counters
    localparam int                 COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration port
    localparam int         CFG_ADDR_W        = 3;
    localparam int         CFG_DATA_W        = 32;
    localparam int         WL_W              = 5;
    localparam logic [WL_W-1:0] WL_RESET     = 5'd5;
    localparam logic       REG_WINDOW_LENGTH = 1'b0;   // word index paddr[2]

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SUM,
        S_DIV,
        S_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // take input word, shift history
        logic setup;      // prepare window of next result
        logic sum_step;   // add one history tap
        logic div_step;   // one quotient bit
        logic load;       // move quotient to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emits;      // word at input produces results
        logic sum_last;   // last tap of window
        logic div_last;   // last quotient bit
        logic out_free;   // output register can take a word
        logic more;       // further flush results pending
    } t_sts;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v != COUNT_MAX) ? v + 1'b1 : v;
    endfunction

endpackage

### hdl/esma_ctrl.sv
// ----------------------------------------------------------------------------
// esma_ctrl
// Sequencer: accept, per-result window setup, serial sum, serial divide, load.
// ----------------------------------------------------------------------------
module esma_ctrl import esma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emits) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.more ? S_SETUP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/esma_datapath.sv
// ----------------------------------------------------------------------------
// esma_datapath
// Sample history, frame counters, serial accumulator, restoring divider and
// output register.
// ----------------------------------------------------------------------------
module esma_datapath import esma_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 15,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [WL_W-1:0]        i_window_length,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_frame_end,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [SAMPLE_BITS-1:0] o_average,
    output logic                   o_last_out
);

    localparam int HIST_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int HIST_W     = $clog2(HIST_DEPTH);
    localparam int HALF_W     = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CNT_W      = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int SUM_W      = SAMPLE_BITS + CNT_W;
    localparam int STEP_W     = $clog2(SUM_W);

    logic [SAMPLE_BITS-1:0] r_hist [HIST_DEPTH];

    logic [COUNT_W-1:0]     r_pos, n_pos;
    logic [COUNT_W-1:0]     r_emit, n_emit;
    logic                   r_end, n_end;
    logic [HALF_W-1:0]      r_d, n_d;
    logic [CNT_W-1:0]       r_divisor, n_divisor;
    logic [CNT_W-1:0]       r_rem, n_rem;
    logic [STEP_W-1:0]      r_step, n_step;
    logic                   r_out_valid, n_out_valid;
    logic [HIST_W-1:0]      r_k, n_k;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [SUM_W-1:0]       r_acc, n_acc;
    logic [SAMPLE_BITS-1:0] r_average, n_average;
    logic                   r_last, n_last;

    logic [HALF_W-1:0]      w_half;
    logic [HALF_W-1:0]      w_top;
    logic [HALF_W-1:0]      w_h;
    logic [CNT_W:0]         w_trial;
    logic                   w_ge;
    logic                   w_final;

    always_comb begin
        // even lengths round up: half = length/2, then clamp
        if (int'(i_window_length[WL_W-1:1]) > MAX_HALF_WIDTH) begin
            w_half = HALF_W'(MAX_HALF_WIDTH);
        end else begin
            w_half = HALF_W'(i_window_length[WL_W-1:1]);
        end
        if (r_pos < COUNT_W'(w_half)) begin
            w_top = r_pos[HALF_W-1:0];
        end else begin
            w_top = w_half;
        end
        // r_d never exceeds half, so the clamp is min(emitted, d)
        if (r_emit < COUNT_W'(r_d)) begin
            w_h = r_emit[HALF_W-1:0];
        end else begin
            w_h = r_d;
        end
        w_trial = {r_rem, r_acc[SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_divisor});
        w_final = r_end && (r_d == '0);
    end

    always_comb begin
        o_sts.emits    = i_frame_end || (r_pos >= COUNT_W'(w_half));
        o_sts.sum_last = (r_cnt == '0);
        o_sts.div_last = (r_step == STEP_W'(SUM_W - 1));
        o_sts.out_free = !r_out_valid || !i_out_stall;
        o_sts.more     = r_end && (r_d != '0);
    end

    always_comb begin
        n_pos       = r_pos;
        n_emit      = r_emit;
        n_end       = r_end;
        n_d         = r_d;
        n_divisor   = r_divisor;
        n_rem       = r_rem;
        n_step      = r_step;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_average   = r_average;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.accept) begin
            n_end = i_frame_end;
            if (i_frame_end) begin
                n_d   = w_top;
                n_pos = '0;
            end else begin
                n_d   = w_half;
                n_pos = sat_inc(r_pos);
            end
        end

        if (i_cmd.setup) begin
            n_k       = HIST_W'(r_d) - HIST_W'(w_h);
            n_cnt     = CNT_W'({w_h, 1'b0});
            n_divisor = CNT_W'({w_h, 1'b1});
            n_rem     = '0;
            n_acc     = '0;
            n_step    = '0;
        end

        if (i_cmd.sum_step) begin
            n_acc = r_acc + SUM_W'(r_hist[r_k]);
            n_k   = r_k + 1'b1;
            n_cnt = r_cnt - 1'b1;
        end

        // restoring divide, quotient shifts into the accumulator
        if (i_cmd.div_step) begin
            n_acc  = {r_acc[SUM_W-2:0], w_ge};
            n_rem  = w_ge ? CNT_W'(w_trial - {1'b0, r_divisor}) : w_trial[CNT_W-1:0];
            n_step = r_step + 1'b1;
        end

        if (i_cmd.load) begin
            n_average   = r_acc[SAMPLE_BITS-1:0];
            n_last      = w_final;
            n_out_valid = 1'b1;
            if (w_final) begin
                n_emit = '0;
            end else begin
                n_emit = sat_inc(r_emit);
                if (r_end) begin
                    n_d = r_d - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_emit      <= '0;
            r_end       <= 1'b0;
            r_d         <= '0;
            r_divisor   <= CNT_W'(1);
            r_rem       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_emit      <= n_emit;
            r_end       <= n_end;
            r_d         <= n_d;
            r_divisor   <= n_divisor;
            r_rem       <= n_rem;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_cnt     <= n_cnt;
        r_acc     <= n_acc;
        r_average <= n_average;
        r_last    <= n_last;
    end

    // history: entry 0 newest, cleared at reset and after a frame flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.load && w_final)) begin
            for (int j = 0; j < HIST_DEPTH; j++) begin
                r_hist[j] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_hist[0] <= i_sample;
            for (int j = 1; j < HIST_DEPTH; j++) begin
                r_hist[j] <= r_hist[j-1];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;
    assign o_last_out  = r_last;

`ifndef SYNTH
    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum_step |-> (r_k <= HIST_W'(HIST_DEPTH - 1)))
        else $error("history tap out of range");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < r_divisor)
        else $error("divider remainder not below divisor");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && w_final) |=> (r_pos == '0 && r_emit == '0 && r_hist[0] == '0))
        else $error("frame state not cleared after flush");
`endif

endmodule

### hdl/edge_shrinking_moving_average_unit.sv
// ----------------------------------------------------------------------------
// edge_shrinking_moving_average_unit
// Sequence: a word with no result is taken in the idle state; each result
//   passes window setup, the one-tap-per-cycle accumulator over its window
//   (clamped half-width), the one-bit-per-cycle divider and a load that
//   waits for a free output register. A frame-end word flushes up to
//   MAX_HALF_WIDTH+1 results back to back. Reset: synchronous, active low;
//   clears counters, history, output valid and sets window_length to 5.
// ----------------------------------------------------------------------------
module edge_shrinking_moving_average_unit import esma_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 15,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    // input words
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_frame_end,
    // result words
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_average,
    output logic                   o_last_out
);

    // ------------------------------------------------------------------
    // Register file: one register, window_length, at byte address 0.
    // Word index is paddr[2]; other words read zero and ignore writes.
    // Writes are expected only while the unit is idle.
    // ------------------------------------------------------------------
    logic [WL_W-1:0] r_window_length;
    logic            w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_RESET;
        end else if (w_cfg_write) begin
            r_window_length <= pwdata[WL_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW_LENGTH: prdata = CFG_DATA_W'(r_window_length);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller / datapath split.
    // The controller walks each accepted word through:
    //   accept -> (per result) setup -> sum -> divide -> load.
    // A mid-frame word gives at most one result (once position >= half);
    // a frame-end word flushes every pending position, shrinking the
    // window toward the frame edge, and marks the final one last_out.
    // The output register decouples the result side: the next input word
    // is accepted while a finished word still waits downstream.
    // ------------------------------------------------------------------
    t_cmd w_cmd;
    t_sts w_sts;

    esma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    esma_datapath #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_window_length (r_window_length),
        .i_sample        (i_sample),
        .i_frame_end     (i_frame_end),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_average       (o_average),
        .o_last_out      (o_last_out)
    );

endmodule

### tb/sv/esma_monitor.sv
// ----------------------------------------------------------------------------
// esma_monitor
// Watches the input, result and register channels of the moving average unit,
// predicts each smoothed word and compares it with the one the block delivers.
// ----------------------------------------------------------------------------
module esma_monitor import esma_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 15,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    input  logic [CFG_DATA_W-1:0]  prdata,
    input  logic                   pready,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_frame_end,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  logic [SAMPLE_BITS-1:0] o_average,
    input  logic                   o_last_out,
    output int                     fail_count,
    output int                     pending_words
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                    DEPTH   = 2 * MAX_HALF_WIDTH + 1;
    localparam logic [CFG_ADDR_W-1:0] WL_ADDR = {REG_WINDOW_LENGTH, 2'b00};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic                   last_out;
    } t_smoothed;

    t_smoothed              expected_averages[$];
    logic [SAMPLE_BITS-1:0] history [DEPTH];     // entry 0 newest
    logic [COUNT_W-1:0]     position_count;
    logic [COUNT_W-1:0]     emitted_count;
    logic [WL_W-1:0]        window_length;
    int                     fails = 0;

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // even lengths (zero too) grow by one
    function automatic int unsigned half_width_of(input logic [WL_W-1:0] wl);
        int unsigned w;
        int unsigned h;
        w = wl;
        if (w % 2 == 0) w++;
        h = (w - 1) / 2;
        if (h > MAX_HALF_WIDTH) h = MAX_HALF_WIDTH;
        return h;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] window_mean(input int unsigned center,
            input int unsigned half, input int unsigned front, input int unsigned back);
        int unsigned       h;
        int unsigned       k;
        longint unsigned   total;
        h = half;
        if (front < h) h = front;
        if (back < h) h = back;
        total = 0;
        for (k = center - h; k <= center + h; k++) total += history[k];
        return SAMPLE_BITS'(total / (2 * h + 1));
    endfunction

    task automatic flag_mismatch(input string what);
        if (fails < 10) $display("%0t ns: %s", $time, what);
        fails++;
    endtask

    task automatic smooth_sample(input logic [SAMPLE_BITS-1:0] s, input logic fend);
        int unsigned half;
        int unsigned p;
        int          d;
        int          k;
        t_smoothed   r;
        half = half_width_of(window_length);
        p    = position_count;
        for (k = DEPTH - 1; k > 0; k--) history[k] = history[k - 1];
        history[0] = s;
        if (fend) begin
            // flush every output still owed, last one is the frame's last sample
            for (d = (p < half) ? p : half; d >= 0; d--) begin
                r.average  = window_mean(d, half, emitted_count, d);
                r.last_out = (d == 0);
                expected_averages.push_back(r);
                emitted_count = count_up(emitted_count);
            end
            position_count = '0;
            emitted_count  = '0;
            for (k = 0; k < DEPTH; k++) history[k] = '0;
        end else begin
            if (p >= half) begin
                r.average  = window_mean(half, half, emitted_count, half);
                r.last_out = 1'b0;
                expected_averages.push_back(r);
                emitted_count = count_up(emitted_count);
            end
            position_count = count_up(position_count);
        end
    endtask

    always @(posedge i_clk) begin
        t_smoothed got;
        t_smoothed want;
        if (!i_rst_n) begin
            expected_averages.delete();
            for (int k = 0; k < DEPTH; k++) history[k] = '0;
            position_count = '0;
            emitted_count  = '0;
            window_length  = WL_RESET;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.average  = o_average;
                got.last_out = o_last_out;
                if (expected_averages.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word: average %h last %b",
                                            got.average, got.last_out));
                end else begin
                    want = expected_averages.pop_front();
                    if (got.average !== want.average || got.last_out !== want.last_out)
                        flag_mismatch($sformatf(
                            "mismatch: average exp %h got %h, last exp %b got %b",
                            want.average, got.average, want.last_out, got.last_out));
                end
            end
            if (i_in_valid && !o_in_stall) smooth_sample(i_sample, i_frame_end);
            if (psel && penable && pready && paddr == WL_ADDR) begin
                if (pwrite)
                    window_length = pwdata[WL_W-1:0];
                else if (prdata[WL_W-1:0] !== window_length)
                    flag_mismatch($sformatf("readback: window_length exp %0d got %0d",
                                            window_length, prdata[WL_W-1:0]));
            end
        end
        pending_words <= expected_averages.size();
        fail_count    <= fails;
    end

endmodule

### tb/sv/tb_edge_shrinking_moving_average_unit.sv
// ----------------------------------------------------------------------------
// tb_edge_shrinking_moving_average_unit
// Drives frames of samples into the moving average unit with bursty input
// and a stalling receiver, retunes the window between phases over the APB
// port, and leaves prediction and comparison to esma_monitor.
// ----------------------------------------------------------------------------
module tb_edge_shrinking_moving_average_unit import esma_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HALF_WIDTH = 15;
    localparam int SAMPLE_BITS    = 24;
    // random words after the directed ones, about 180 words in all
    localparam int RANDOM_WORDS   = 155;
    // slowest single result: widest window plus the bit-serial divide
    localparam int RESULT_CYCLES  = 2 * MAX_HALF_WIDTH + SAMPLE_BITS
                                    + $clog2(2 * MAX_HALF_WIDTH + 2) + 3;
    localparam int DRAIN_CYCLES   = RESULT_CYCLES + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [CFG_ADDR_W-1:0]  WL_ADDR    = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   i_frame_end;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [SAMPLE_BITS-1:0] o_average;
    logic                   o_last_out;
    int                     fail_count;
    int                     pending_words;

    // stimulus bookkeeping
    logic [WL_W-1:0] cur_wl = WL_RESET;  // only used to shape frame lengths
    int              burst_left = 0;
    int              frame_left = 0;
    int              random_words = 0;
    int              quiet_cycles = 0;
    int              stall_mode = 0;
    int              mode_left = 0;

    always #5 i_clk = ~i_clk;

    edge_shrinking_moving_average_unit #(
        .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) uut (.*);

    esma_monitor #(
        .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) monitor (.*);

    // ---- receiver: stall pattern of its own --------------------------------
    // Modes rotate after a random run: free flowing, coin flip, and
    // mostly stalled, so backpressure lands on every part of a flush.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= $urandom_range(0, 1);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ---- watchdog: cycles with no word moving on any channel ---------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** edge_shrinking_moving_average_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---- input side ---------------------------------------------------------
    task automatic release_input();
        @(negedge i_clk) i_in_valid <= 1'b0;
    endtask

    // Presents one word and holds it until the block takes it. Valid stays
    // high when the next word follows straight away.
    task automatic push_word(input logic [SAMPLE_BITS-1:0] s, input logic fend);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_sample    <= s;
        i_frame_end <= fend;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Bursts of 1..12 words; gaps mostly short, now and then none or long.
    task automatic feed(input logic [SAMPLE_BITS-1:0] s, input logic fend);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                3:       gap = $urandom_range(5, 15);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                release_input();
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        push_word(s, fend);
    endtask

    // ---- register port --------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= WL_ADDR;
        pwdata  <= data;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every predicted word is out, then give a word with no result
    // time to finish behind it.
    task automatic settle();
        release_input();
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Junk in the upper bits checks that only the 5-bit field is kept; the
    // read-back is compared by the monitor.
    task automatic reconfigure(input logic [WL_W-1:0] wl);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        data[WL_W-1:0] = wl;
        settle();
        apb_access(1'b1, data);
        apb_access(1'b0, '0);
        cur_wl = wl;
    endtask

    // ---- random content -------------------------------------------------------
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return '0;
            2:       return SAMPLE_BITS'($urandom_range(0, 15));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly frames around the window size, so both shrinking edges and a
    // stretch of full windows show up; some single-word and long frames.
    function automatic int pick_frame_length(input logic [WL_W-1:0] wl);
        int w;
        int h;
        w = wl;
        if (w % 2 == 0) w++;
        h = (w - 1) / 2;
        case ($urandom_range(0, 9))
            0:       return 1;
            7, 8:    return $urandom_range(2 * h + 5, 2 * h + 20);
            9:       return $urandom_range(1, 3);
            default: return $urandom_range(2, 2 * h + 4);
        endcase
    endfunction

    function automatic logic [WL_W-1:0] pick_window();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WL_W'(1);
            3:       return WL_W'(30);
            default: return WL_W'($urandom_range(0, 31));
        endcase
    endfunction

    // ---- main sequence ----------------------------------------------------------
    initial begin
        int phase_words;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_frame_end = 1'b0;
        i_out_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset value of the window register
        apb_access(1'b0, '0);

        // one-word frame passes straight through
        feed(SAMPLE_MAX, 1'b1);
        // frame shorter than the default window of 5
        feed(SAMPLE_MAX, 1'b0);
        feed('0, 1'b0);
        feed(SAMPLE_MAX, 1'b1);
        // extremes alternating across full and shrinking windows
        for (int i = 0; i < 8; i++) feed((i % 2 == 0) ? SAMPLE_MAX : '0, i == 7);

        // zero length acts as one: pure pass-through
        reconfigure('0);
        feed(pick_sample(), 1'b0);
        feed(pick_sample(), 1'b1);

        // widest window on a short all-max frame: clamped on both sides
        reconfigure('1);
        for (int i = 0; i < 7; i++) feed(SAMPLE_MAX, i == 6);

        // even length raised by one, then retuned in the middle of the frame
        reconfigure(WL_W'(2));
        feed(pick_sample(), 1'b0);
        feed(pick_sample(), 1'b0);
        reconfigure(WL_W'(9));
        feed(pick_sample(), 1'b0);
        feed(pick_sample(), 1'b1);

        // random phases; frames carry over phase boundaries, so some window
        // changes land mid-frame
        while (random_words < RANDOM_WORDS) begin
            phase_words = $urandom_range(10, 40);
            if (phase_words > RANDOM_WORDS - random_words)
                phase_words = RANDOM_WORDS - random_words;
            repeat (phase_words) begin
                if (frame_left == 0) frame_left = pick_frame_length(cur_wl);
                feed(pick_sample(), frame_left == 1);
                frame_left--;
                random_words++;
            end
            reconfigure(pick_window());
        end

        settle();
        if (fail_count == 0 && pending_words == 0) begin
            $display("** edge_shrinking_moving_average_unit: PASSED **");
        end else begin
            $display("** edge_shrinking_moving_average_unit: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/esma_pkg.sv
hdl/esma_ctrl.sv
hdl/esma_datapath.sv
hdl/edge_shrinking_moving_average_unit.sv
tb/sv/esma_monitor.sv
tb/sv/tb_edge_shrinking_moving_average_unit.sv
